>>> rtl/per_bank_refresh_scheduler_top_defines.svh
// Assertion macros shared by the refresh scheduler RTL.
// Each macro expects clk and rst_n in scope.
`ifndef PER_BANK_REFRESH_SCHEDULER_TOP_DEFINES_SVH
`define PER_BANK_REFRESH_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication
`define PBRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PBRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pbrs_pkg.sv
`timescale 1ns / 1ps

package pbrs_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;

    // Result word geometry
    localparam int BANK_INDEX_W = 6;
    localparam int OUT_TDATA_W  = 16;

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_REFRESH_INTERVAL  = 2'd0,
        REG_BANK_REFRESH_TIME = 2'd1,
        REG_SET_PAUSE_ENABLE  = 2'd2,
        REG_BANK_COUNT        = 2'd3
    } cfg_index_t;

    // Register reset values
    localparam logic [15:0] RST_REFRESH_INTERVAL  = 16'd3900;
    localparam logic [15:0] RST_BANK_REFRESH_TIME = 16'd0;
    localparam logic        RST_SET_PAUSE_ENABLE  = 1'b0;
    localparam logic [6:0]  RST_BANK_COUNT        = 7'd16;

    typedef struct packed {
        logic [15:0] refresh_interval;
        logic [15:0] bank_refresh_time;
        logic        set_pause_enable;
        logic [6:0]  bank_count;
    } pbrs_cfg_t;

endpackage

>>> rtl/pbrs_cfg_regs.sv
`timescale 1ns / 1ps

module pbrs_cfg_regs
    import pbrs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output pbrs_cfg_t              cfg
);

    pbrs_cfg_t cfg_reg;
    pbrs_cfg_t cfg_next;

    // Decode the write into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_index))
                REG_REFRESH_INTERVAL:  cfg_next.refresh_interval  = cfg_data;
                REG_BANK_REFRESH_TIME: cfg_next.bank_refresh_time = cfg_data;
                REG_SET_PAUSE_ENABLE:  cfg_next.set_pause_enable  = cfg_data[0];
                REG_BANK_COUNT:        cfg_next.bank_count        = cfg_data[6:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.refresh_interval  <= RST_REFRESH_INTERVAL;
            cfg_reg.bank_refresh_time <= RST_BANK_REFRESH_TIME;
            cfg_reg.set_pause_enable  <= RST_SET_PAUSE_ENABLE;
            cfg_reg.bank_count        <= RST_BANK_COUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/per_bank_refresh_scheduler_top.sv
`timescale 1ns / 1ps
// Each accepted input word is held in the input register, then in the result register.
// Throughput: one word per cycle unless m_tready stalls the output; the schedule state
// (due time, bank pointer, boundary wait, resume time) is set by the compare/add step.
// Reset (rst_n, async, active low): registers return to their reset values, due time
// to 3900, bank pointer to 0, no boundary pending, resume time 0, both stages empty.

module per_bank_refresh_scheduler_top
    import pbrs_pkg::*;
#(
    parameter int MAX_BANKS  = 64,
    parameter int TIME_WIDTH = 48
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration write port
    input  logic                                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]                 cfg_index,
    input  logic [CFG_DATA_W-1:0]                  cfg_data,
    // Input stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // tdata: now, last_issue_time, zero fill
    input  logic [((2*TIME_WIDTH+7)/8)*8-1:0]      s_tdata,
    // tuser: history_present
    input  logic                                   s_tuser,
    // Result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // tdata: refresh_request, bank_index[5:0], history_error, pausing, zero fill
    output logic [OUT_TDATA_W-1:0]                 m_tdata
);

    `include "per_bank_refresh_scheduler_top_defines.svh"

    localparam int BANK_W = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
    localparam int CNT_W  = $clog2(MAX_BANKS + 1);
    localparam int NW     = (CNT_W > 7) ? CNT_W : 7;

    pbrs_cfg_t cfg;

    pbrs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register
    logic                  s1_valid_reg;
    logic [TIME_WIDTH-1:0] s1_now_reg;
    logic [TIME_WIDTH-1:0] s1_issued_reg;
    logic                  s1_present_reg;

    // Schedule state
    logic [TIME_WIDTH-1:0] due_reg,    due_next;
    logic [BANK_W-1:0]     bank_reg,   bank_next;
    logic                  pend_reg,   pend_next;
    logic [TIME_WIDTH-1:0] breq_reg,   breq_next;
    logic [TIME_WIDTH-1:0] resume_reg, resume_next;

    // Result register
    logic                    res_valid_reg;
    logic                    res_req_reg;
    logic [BANK_INDEX_W-1:0] res_bank_reg;
    logic                    res_error_reg;
    logic                    res_pausing_reg;

    logic out_free;
    logic advance;

    // Step logic
    logic [TIME_WIDTH:0]   sum_wide;
    logic [TIME_WIDTH-1:0] sum_sat;
    logic                  clear;
    logic                  err;
    logic                  pend_mid;
    logic                  resume_ok;
    logic                  fire;
    logic [NW-1:0]         cnt_ext;
    logic [NW-1:0]         n_eff;
    logic [BANK_W-1:0]     b_sel;
    logic [NW-1:0]         b_inc;
    logic                  last;
    logic                  start_pause;

    // Handshake: stage 1 drains into the result register when that is free
    assign out_free = !res_valid_reg || m_tready;
    assign advance  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;

    // Capture the input word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            s1_now_reg     <= s_tdata[TIME_WIDTH-1:0];
            s1_issued_reg  <= s_tdata[2*TIME_WIDTH-1:TIME_WIDTH];
            s1_present_reg <= s_tuser;
        end
    end

    // Resolve the boundary wait, then decide on a request
    always_comb
    begin
        sum_wide  = {1'b0, s1_issued_reg} + (TIME_WIDTH+1)'(cfg.bank_refresh_time);
        sum_sat   = sum_wide[TIME_WIDTH] ? '1 : sum_wide[TIME_WIDTH-1:0];
        clear     = pend_reg && s1_present_reg && (s1_issued_reg >= breq_reg);
        err       = pend_reg && !s1_present_reg;
        pend_mid  = pend_reg && !clear;
        resume_ok = clear ? (s1_now_reg >= sum_sat) : (s1_now_reg >= resume_reg);
        fire      = (s1_now_reg >= due_reg) && !pend_mid && resume_ok;

        // Clamp the bank count to 1..MAX_BANKS
        cnt_ext = NW'(cfg.bank_count);
        if (cnt_ext == '0)
        begin
            n_eff = NW'(1);
        end
        else if (cnt_ext > NW'(MAX_BANKS))
        begin
            n_eff = NW'(MAX_BANKS);
        end
        else
        begin
            n_eff = cnt_ext;
        end

        // Restart at bank 0 if the pointer ran past a lowered count
        b_sel       = (NW'(bank_reg) >= n_eff) ? '0 : bank_reg;
        b_inc       = NW'(b_sel) + NW'(1);
        last        = (b_inc >= n_eff);
        start_pause = fire && cfg.set_pause_enable && last;

        due_next    = fire ? (due_reg + TIME_WIDTH'(cfg.refresh_interval)) : due_reg;
        bank_next   = fire ? (last ? '0 : b_inc[BANK_W-1:0]) : bank_reg;
        pend_next   = start_pause ? 1'b1 : pend_mid;
        breq_next   = start_pause ? s1_now_reg : (clear ? '0 : breq_reg);
        resume_next = clear ? sum_sat : resume_reg;
    end

    // Advance the schedule state once per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_reg    <= TIME_WIDTH'(RST_REFRESH_INTERVAL);
            bank_reg   <= '0;
            pend_reg   <= 1'b0;
            breq_reg   <= '0;
            resume_reg <= '0;
        end
        else if (advance)
        begin
            due_reg    <= due_next;
            bank_reg   <= bank_next;
            pend_reg   <= pend_next;
            breq_reg   <= breq_next;
            resume_reg <= resume_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_req_reg     <= fire;
            res_bank_reg    <= fire ? BANK_INDEX_W'(b_sel) : '0;
            res_error_reg   <= err;
            res_pausing_reg <= pend_next;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-BANK_INDEX_W-3){1'b0}},
                       res_pausing_reg, res_error_reg, res_bank_reg, res_req_reg};

    // Checks
    `PBRS_ASSERT_NEXT(a_err_missing_history, advance && pend_reg && !s1_present_reg,
        res_error_reg, "missing history did not raise the error flag")
    `PBRS_ASSERT_NEXT(a_no_req_while_paused, advance && pend_reg && !clear,
        !res_req_reg, "request issued while boundary still pending")
    `PBRS_ASSERT_NEXT(a_pausing_tracks_state, advance,
        res_pausing_reg == pend_reg, "pausing flag differs from boundary state")
    `PBRS_ASSERT_NOW(a_pause_needs_enable, $rose(pend_reg),
        $past(cfg.set_pause_enable), "boundary wait started with set pause off")

endmodule
